// ===== design/assert_macros.svh =====
// Assertion macros shared by the sensor bin frequency table RTL.
// No dependencies; the asserting modules include this file by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SBFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define SBFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== design/sbft_pkg.sv =====
// Shared types and constants of the sensor bin frequency table.
// No dependencies; used by every module of the block.
`default_nettype none

package sbft_pkg;

    localparam int READ_W  = 11;  // sensor reading and limit registers
    localparam int BCNT_W  = 4;   // bin count register
    localparam int BIN_W   = 4;   // bin field on the result channel
    localparam int SLOT_W  = 3;   // slot field on the result channel
    localparam int CNT_W   = 8;   // occurrence counter
    localparam int SUB_W   = 12;  // shared subtractor
    localparam int CFG_IDX_W = 2;

    localparam logic [READ_W-1:0] MIN_RESET  = 11'd0;
    localparam logic [READ_W-1:0] MAX_RESET  = 11'd800;
    localparam logic [BCNT_W-1:0] BINS_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN  = 2'd0,
        CFG_MAX  = 2'd1,
        CFG_BINS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             borrow;
        logic             zero;
    } sub_res_t;

    typedef struct packed {
        logic idle;
        logic hold;
    } quant_stat_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              fresh;
    } tbl_res_t;

endpackage

`default_nettype wire

// ===== design/sbft_sub.sv =====
// Shared subtract and compare unit of the quantizer.
// Depends on sbft_pkg for the operand width and the result struct.
`default_nettype none

module sbft_sub (
    input  wire logic [sbft_pkg::SUB_W-1:0] a,
    input  wire logic [sbft_pkg::SUB_W-1:0] b,
    output sbft_pkg::sub_res_t              res
);

    logic [sbft_pkg::SUB_W:0] full;

    assign full       = {1'b0, a} - {1'b0, b};
    assign res.diff   = full[sbft_pkg::SUB_W-1:0];
    assign res.borrow = full[sbft_pkg::SUB_W];
    assign res.zero   = (full[sbft_pkg::SUB_W-1:0] == '0);

endmodule

`default_nettype wire

// ===== design/sbft_quant.sv =====
// Quantizer sequencer: span, offset, serial divide and ceiling loop on one subtractor.
// Depends on sbft_pkg, sbft_sub and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbft_quant #(
    parameter int NUM_BINS = 8,
    parameter int NB_W     = $clog2(NUM_BINS + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sbft_pkg::READ_W-1:0] reading,
    input  wire logic [sbft_pkg::READ_W-1:0] min_reading,
    input  wire logic [sbft_pkg::READ_W-1:0] max_reading,
    input  wire logic [sbft_pkg::BCNT_W-1:0] bin_count,
    input  wire logic                        out_free,
    output sbft_pkg::quant_stat_t            stat,
    output logic                             upd,
    output logic [NB_W-1:0]                  bin
);

    localparam int RW   = sbft_pkg::READ_W;
    localparam int DC_W = $clog2(RW);
    localparam logic [DC_W-1:0] DIV_LAST = DC_W'(RW - 1);
    localparam logic [4:0]      NB_MAX   = 5'(NUM_BINS);

    typedef enum logic [5:0] {
        Q_IDLE = 6'b000001,
        Q_SPAN = 6'b000010,
        Q_DIFF = 6'b000100,
        Q_DIV  = 6'b001000,
        Q_CEIL = 6'b010000,
        Q_HOLD = 6'b100000
    } qstate_t;

    qstate_t           state_reg, state_next;
    logic [RW-1:0]     reading_reg, reading_next;
    logic [RW-1:0]     div_reg, div_next;
    logic [NB_W-1:0]   rem_reg, rem_next;
    logic [RW-1:0]     r_reg, r_next;
    logic [NB_W-1:0]   k_reg, k_next;
    logic [DC_W-1:0]   cnt_reg, cnt_next;
    logic              le_reg, le_next;
    logic [NB_W-1:0]   bin_reg, bin_next;

    logic [4:0]        bc5, n5;
    logic [NB_W-1:0]   n;
    logic [NB_W:0]     trial;
    logic              qbit;
    logic [sbft_pkg::SUB_W-1:0] opa, opb;
    sbft_pkg::sub_res_t         sres;

    // Effective bin count: zero counts as one, anything above the table as its size.
    always_comb begin
        bc5 = {1'b0, bin_count};
        if (bc5 == 5'd0) begin
            n5 = 5'd1;
        end else if (bc5 > NB_MAX) begin
            n5 = NB_MAX;
        end else begin
            n5 = bc5;
        end
        n = n5[NB_W-1:0];
    end

    assign trial = {rem_reg, div_reg[RW-1]};
    assign qbit  = !sres.borrow;

    always_comb begin
        unique case (state_reg)
            Q_SPAN: begin
                opa = sbft_pkg::SUB_W'(max_reading);
                opb = sbft_pkg::SUB_W'(min_reading);
            end
            Q_DIFF: begin
                opa = sbft_pkg::SUB_W'(reading_reg);
                opb = sbft_pkg::SUB_W'(min_reading);
            end
            Q_DIV: begin
                opa = sbft_pkg::SUB_W'(trial);
                opb = sbft_pkg::SUB_W'(n);
            end
            Q_CEIL: begin
                opa = sbft_pkg::SUB_W'(r_reg);
                opb = sbft_pkg::SUB_W'(div_reg);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    sbft_sub u_sub (
        .a   (opa),
        .b   (opb),
        .res (sres)
    );

    always_comb begin
        state_next   = state_reg;
        reading_next = reading_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        r_next       = r_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        le_next      = le_reg;
        bin_next     = bin_reg;
        unique case (state_reg)
            Q_IDLE: begin
                if (start) begin
                    reading_next = reading;
                    state_next   = Q_SPAN;
                end
            end
            Q_SPAN: begin
                div_next   = (sres.borrow || sres.zero) ? '0 : RW'(sres.diff);
                state_next = Q_DIFF;
            end
            Q_DIFF: begin
                le_next    = sres.borrow || sres.zero;
                r_next     = RW'(sres.diff);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = Q_DIV;
            end
            Q_DIV: begin
                rem_next = qbit ? NB_W'(sres.diff) : NB_W'(trial);
                div_next = {div_reg[RW-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    if (le_reg) begin
                        bin_next   = NB_W'(1);
                        state_next = Q_HOLD;
                    end else if (div_next == '0) begin
                        bin_next   = n;
                        state_next = Q_HOLD;
                    end else begin
                        k_next     = NB_W'(1);
                        state_next = Q_CEIL;
                    end
                end
            end
            Q_CEIL: begin
                if (k_reg == n || sres.borrow || sres.zero) begin
                    bin_next   = k_reg;
                    state_next = Q_HOLD;
                end else begin
                    r_next = RW'(sres.diff);
                    k_next = k_reg + 1'b1;
                end
            end
            Q_HOLD: begin
                if (out_free) begin
                    state_next = Q_IDLE;
                end
            end
            default: begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Q_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        reading_reg <= reading_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        r_reg       <= r_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        le_reg      <= le_next;
        bin_reg     <= bin_next;
    end

    assign stat.idle = (state_reg == Q_IDLE);
    assign stat.hold = (state_reg == Q_HOLD);
    assign upd       = stat.hold && out_free;
    assign bin       = bin_reg;

    `SBFT_ASSERT(a_bin_in_range,
        stat.hold |-> (bin_reg != '0 && bin_reg <= NB_W'(NUM_BINS)),
        "quantized bin outside 1..NUM_BINS")

    `SBFT_ASSERT(a_div_length,
        (state_reg == Q_DIV && cnt_reg != DIV_LAST) |=> state_reg == Q_DIV,
        "serial divide left before its last step")

endmodule

`default_nettype wire

// ===== design/sbft_table.sv =====
// Bin-to-slot map with first-seen slot allocation and per-slot counters.
// Depends on sbft_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbft_table #(
    parameter int NUM_BINS    = 8,
    parameter int TABLE_SLOTS = 8,
    parameter int NB_W        = $clog2(NUM_BINS + 1)
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       upd,
    input  wire logic [NB_W-1:0] bin,
    output sbft_pkg::tbl_res_t   res
);

    localparam int KEY_W = $clog2(NUM_BINS);
    localparam int SL_W  = $clog2(TABLE_SLOTS);
    localparam int NS_W  = $clog2(TABLE_SLOTS + 1);
    localparam logic [NS_W-1:0] SLOTS_END = NS_W'(TABLE_SLOTS);

    logic [NUM_BINS-1:0]     valid_reg, valid_next;
    logic [SL_W-1:0]         map_reg [NUM_BINS];
    logic [sbft_pkg::CNT_W-1:0] cnt_reg [TABLE_SLOTS];
    logic [NS_W-1:0]         next_reg, next_next;

    logic [KEY_W-1:0]        key;
    logic                    hit, room;
    logic [SL_W-1:0]         slot_hit, slot_new, slot_sel;
    logic [sbft_pkg::CNT_W-1:0] cnt_inc;

    assign key      = KEY_W'(bin - NB_W'(1));
    assign hit      = valid_reg[key];
    assign slot_hit = map_reg[key];
    assign slot_new = SL_W'(next_reg);
    assign room     = (next_reg < SLOTS_END);
    assign slot_sel = hit ? slot_hit : slot_new;
    assign cnt_inc  = cnt_reg[slot_hit] + 1'b1;

    always_comb begin
        valid_next = valid_reg;
        next_next  = next_reg;
        if (upd && !hit && room) begin
            valid_next[key] = 1'b1;
            next_next       = next_reg + 1'b1;
        end
    end

    // A bin that is new while the table is full is dropped with slot and count of zero.
    always_comb begin
        if (hit) begin
            res.slot  = sbft_pkg::SLOT_W'(slot_hit);
            res.count = cnt_inc;
            res.fresh = 1'b0;
        end else if (room) begin
            res.slot  = sbft_pkg::SLOT_W'(slot_new);
            res.count = sbft_pkg::CNT_W'(1);
            res.fresh = 1'b1;
        end else begin
            res.slot  = '0;
            res.count = '0;
            res.fresh = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            next_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            next_reg  <= next_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd && (hit || room)) begin
            cnt_reg[slot_sel] <= hit ? cnt_inc : sbft_pkg::CNT_W'(1);
        end
        if (upd && !hit && room) begin
            map_reg[key] <= slot_new;
        end
    end

    `SBFT_ASSERT(a_next_bounded,
        next_reg <= SLOTS_END,
        "next free slot beyond the table")

    `SBFT_ASSERT(a_alloc_advances,
        (upd && res.fresh) |=> next_reg == $past(next_reg) + 1'b1,
        "new entry did not advance the free slot")

endmodule

`default_nettype wire

// ===== design/sensor_bin_frequency_table.sv =====
// Top level of the sensor bin frequency table: config registers, quantizer,
// slot table and result register. Depends on sbft_pkg, sbft_quant, sbft_table.
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      s_reading
//   m_        out        m_valid / m_ready      m_bin, m_slot, m_count, m_new_entry
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input beat is taken only while the quantizer is idle. From acceptance the
// result passes through the span and offset steps, the serial divide and a ceiling
// loop of up to n trials (n = effective bin count), all on the one shared
// subtractor, and then through the table update into the result register.
// A result waiting on m_ready does not stop the next beat being accepted; only a
// second finished result waits in the quantizer until the output register frees.
// Reset is synchronous and active low; it clears the map's valid bits and the free
// slot pointer at once, so there is no clearing pass. Config beats are always taken.
`default_nettype none

module sensor_bin_frequency_table #(
    parameter int NUM_BINS    = 8,
    parameter int TABLE_SLOTS = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [sbft_pkg::READ_W-1:0]    s_reading,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [sbft_pkg::BIN_W-1:0]          m_bin,
    output logic [sbft_pkg::SLOT_W-1:0]         m_slot,
    output logic [sbft_pkg::CNT_W-1:0]          m_count,
    output logic                                m_new_entry,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sbft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sbft_pkg::READ_W-1:0]    cfg_data
);

    localparam int NB_W = $clog2(NUM_BINS + 1);

    logic [sbft_pkg::READ_W-1:0] min_reg, max_reg;
    logic [sbft_pkg::BCNT_W-1:0] bins_reg;

    sbft_pkg::quant_stat_t qstat;
    sbft_pkg::tbl_res_t    tres;
    logic                  upd, out_free;
    logic [NB_W-1:0]       qbin;

    logic                        m_valid_reg, m_valid_next;
    logic [sbft_pkg::BIN_W-1:0]  m_bin_reg;
    logic [sbft_pkg::SLOT_W-1:0] m_slot_reg;
    logic [sbft_pkg::CNT_W-1:0]  m_count_reg;
    logic                        m_new_reg;

    // Configuration registers: an index beyond the list is simply ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= sbft_pkg::MIN_RESET;
            max_reg  <= sbft_pkg::MAX_RESET;
            bins_reg <= sbft_pkg::BINS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == sbft_pkg::CFG_MIN) begin
                min_reg <= cfg_data;
            end else if (cfg_index == sbft_pkg::CFG_MAX) begin
                max_reg <= cfg_data;
            end else if (cfg_index == sbft_pkg::CFG_BINS) begin
                bins_reg <= cfg_data[sbft_pkg::BCNT_W-1:0];
            end
        end
    end

    assign s_ready  = qstat.idle;
    assign out_free = !m_valid_reg || m_ready;

    sbft_quant #(
        .NUM_BINS (NUM_BINS),
        .NB_W     (NB_W)
    ) u_quant (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_valid && s_ready),
        .reading     (s_reading),
        .min_reading (min_reg),
        .max_reading (max_reg),
        .bin_count   (bins_reg),
        .out_free    (out_free),
        .stat        (qstat),
        .upd         (upd),
        .bin         (qbin)
    );

    sbft_table #(
        .NUM_BINS    (NUM_BINS),
        .TABLE_SLOTS (TABLE_SLOTS),
        .NB_W        (NB_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .bin     (qbin),
        .res     (tres)
    );

    // The result register is loaded on the same edge as the table update.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (upd) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            m_bin_reg   <= sbft_pkg::BIN_W'(qbin);
            m_slot_reg  <= tres.slot;
            m_count_reg <= tres.count;
            m_new_reg   <= tres.fresh;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin       = m_bin_reg;
    assign m_slot      = m_slot_reg;
    assign m_count     = m_count_reg;
    assign m_new_entry = m_new_reg;

endmodule

`default_nettype wire
